### hdl/fnvc_pkg.sv
// Shared types and constants for the file name checker.
package fnvc_pkg;

	localparam int MAX_NAME_LENGTH = 256;
	localparam int CNT_W           = $clog2(MAX_NAME_LENGTH + 1);
	localparam int LEAD_DEPTH      = 6;
	localparam int LEAD_IDX_W      = 3;
	localparam int CHAR_W          = 16;
	localparam int CODE_W          = 7;
	localparam int QUEUE_DEPTH     = 2;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [1:0] {
		VERDICT_VALID     = 2'd0,
		VERDICT_LEAD_DOT  = 2'd1,
		VERDICT_DOTS_ONLY = 2'd2,
		VERDICT_INVALID   = 2'd3
	} verdict_t;

	// One classified character as it travels through the queue.
	typedef struct packed {
		logic  term;
		logic  dot;
		logic  bad;
		code_t code;   // upper-case folded ASCII, zero for anything above 0x7F
	} class_t;

	localparam char_t CHAR_NUL = 16'h0000;
	localparam char_t CHAR_DOT = 16'h002E;

	localparam code_t CH_DOLLAR = 7'h24;
	localparam code_t CH_ONE    = 7'h31;
	localparam code_t CH_NINE   = 7'h39;
	localparam code_t CH_A      = 7'h41;
	localparam code_t CH_C      = 7'h43;
	localparam code_t CH_K      = 7'h4B;
	localparam code_t CH_L      = 7'h4C;
	localparam code_t CH_M      = 7'h4D;
	localparam code_t CH_N      = 7'h4E;
	localparam code_t CH_O      = 7'h4F;
	localparam code_t CH_P      = 7'h50;
	localparam code_t CH_R      = 7'h52;
	localparam code_t CH_T      = 7'h54;
	localparam code_t CH_U      = 7'h55;
	localparam code_t CH_X      = 7'h58;

endpackage

### hdl/fnvc_front.sv
// Front end: accepts characters and classifies them for the queue.
module fnvc_front
	import fnvc_pkg::*;
(
	input  logic   char_valid,
	output logic   char_ready,
	input  char_t  character,
	input  logic   queue_full,
	output logic   push,
	output class_t push_data
);

	logic forbidden;

	assign char_ready = !queue_full;
	assign push       = char_valid && !queue_full;

	always_comb begin
		if (character < 16'h0020) begin
			forbidden = 1'b1;
		end else if (character >= 16'h0040) begin
			forbidden = character inside {16'h005C, 16'h007C};
		end else begin
			forbidden = character inside {16'h0022, 16'h002A, 16'h002F, 16'h003A,
				16'h003C, 16'h003E, 16'h003F};
		end
	end

	always_comb begin
		push_data.term = (character == CHAR_NUL);
		push_data.dot  = (character == CHAR_DOT);
		push_data.bad  = forbidden;
		if (character inside {[16'h0061:16'h007A]}) begin
			push_data.code = character[CODE_W-1:0] & ~code_t'(7'h20);
		end else if (character < 16'h0080) begin
			push_data.code = character[CODE_W-1:0];
		end else begin
			push_data.code = '0;
		end
	end

endmodule

### hdl/fnvc_queue.sv
// Two-entry queue that decouples the front end from the back end.
module fnvc_queue
	import fnvc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  class_t push_data,
	output logic   full,
	input  logic   pop,
	output class_t pop_data,
	output logic   empty
);

	class_t     mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = (fill_q == 2'(QUEUE_DEPTH));
	assign empty    = (fill_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### hdl/fnvc_back.sv
// Back end: accumulates name state per character and issues the verdict.
module fnvc_back
	import fnvc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     queue_empty,
	input  class_t   pop_data,
	output logic     pop,
	output logic     verdict_valid,
	input  logic     verdict_ready,
	output verdict_t verdict
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] first_dot_q;
	logic             dot_seen_q;
	logic             non_dot_q;
	logic             bad_q;
	code_t            lead_q [LEAD_DEPTH];
	logic             out_valid_q;
	verdict_t         out_verdict_q;

	logic             out_free;
	logic             below_max;
	logic [CNT_W-1:0] stem;
	logic             reserved;
	verdict_t         decision;

	assign out_free      = !out_valid_q || verdict_ready;
	assign pop           = !queue_empty && (!pop_data.term || out_free);
	assign below_max     = (count_q < CNT_W'(MAX_NAME_LENGTH));
	assign stem          = dot_seen_q ? first_dot_q : count_q;
	assign verdict_valid = out_valid_q;
	assign verdict       = out_verdict_q;

	always_comb begin
		reserved = 1'b0;
		if (stem == CNT_W'(3)) begin
			reserved = (lead_q[0] == CH_A && lead_q[1] == CH_U && lead_q[2] == CH_X) ||
				(lead_q[0] == CH_C && lead_q[1] == CH_O && lead_q[2] == CH_N) ||
				(lead_q[0] == CH_N && lead_q[1] == CH_U && lead_q[2] == CH_L) ||
				(lead_q[0] == CH_P && lead_q[1] == CH_R && lead_q[2] == CH_N);
		end else if (stem == CNT_W'(4)) begin
			reserved = ((lead_q[0] == CH_C && lead_q[1] == CH_O && lead_q[2] == CH_M) ||
				(lead_q[0] == CH_L && lead_q[1] == CH_P && lead_q[2] == CH_T)) &&
				lead_q[3] >= CH_ONE && lead_q[3] <= CH_NINE;
		end else if (stem == CNT_W'(6)) begin
			reserved = lead_q[0] == CH_C && lead_q[1] == CH_L && lead_q[2] == CH_O &&
				lead_q[3] == CH_C && lead_q[4] == CH_K && lead_q[5] == CH_DOLLAR;
		end
	end

	always_comb begin
		if (bad_q || !below_max) begin
			decision = VERDICT_INVALID;
		end else if (!non_dot_q) begin
			decision = VERDICT_DOTS_ONLY;
		end else if (dot_seen_q && first_dot_q == '0) begin
			decision = VERDICT_LEAD_DOT;
		end else if (reserved) begin
			decision = VERDICT_INVALID;
		end else begin
			decision = VERDICT_VALID;
		end
	end

	// Leading characters need no reset: only entries written for this name are read.
	always_ff @(posedge clk) begin
		if (pop && !pop_data.term && count_q < CNT_W'(LEAD_DEPTH)) begin
			lead_q[count_q[LEAD_IDX_W-1:0]] <= pop_data.code;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.term) begin
			out_verdict_q <= decision;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			first_dot_q <= '0;
			dot_seen_q  <= 1'b0;
			non_dot_q   <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_data.term) begin
				out_valid_q <= 1'b1;
			end else if (verdict_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_data.term) begin
					count_q     <= '0;
					first_dot_q <= '0;
					dot_seen_q  <= 1'b0;
					non_dot_q   <= 1'b0;
					bad_q       <= 1'b0;
				end else if (below_max) begin
					if (pop_data.dot) begin
						if (!dot_seen_q) begin
							dot_seen_q  <= 1'b1;
							first_dot_q <= count_q;
						end
					end else begin
						non_dot_q <= 1'b1;
						if (pop_data.bad) begin
							bad_q <= 1'b1;
						end
					end
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NAME_LENGTH))
		else $error("character count passed the length limit");

	a_dot_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!dot_seen_q |-> first_dot_q == '0)
		else $error("first dot position set without a dot");

	a_dot_in_name: assert property (@(posedge clk) disable iff (!arst_n)
		dot_seen_q |-> first_dot_q < count_q)
		else $error("first dot lies beyond the characters taken");

	a_term_yields_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_data.term) |=> (out_valid_q && count_q == '0))
		else $error("terminator did not produce a verdict");

endmodule

### hdl/file_name_validity_checker_top.sv
// Top level of the file name validity checker: front end, queue and back end.
//
//  channel    valid          ready          payload
//  ---------  -------------  -------------  -------------------------------
//  input      char_valid     char_ready     character[15:0], 0 ends a name
//  output     verdict_valid  verdict_ready  verdict[1:0], one per name
//
// One character per cycle sustained while verdicts are taken; the front end
// takes a character every cycle while the two-entry queue has room, and the
// back end drains one entry per cycle unless a terminator waits on a stalled
// verdict. A verdict is registered at the edge that pops its terminator from the
// queue. arst_n clears all control state; no clearing pass is needed.
// A stalled verdict holds the terminator in the queue, while characters of
// the next name keep flowing until the queue fills.
module file_name_validity_checker_top
	import fnvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [15:0] character,
	output logic        verdict_valid,
	input  logic        verdict_ready,
	output logic [1:0]  verdict
);

	class_t   push_data;
	class_t   pop_data;
	logic     push;
	logic     pop;
	logic     queue_full;
	logic     queue_empty;
	verdict_t verdict_code;

	// Classify the incoming transaction and push it when the queue has room.
	fnvc_front u_front (
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// Hold classified characters so each side can stall on its own.
	fnvc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	// Advance the name state and register the verdict on each terminator.
	fnvc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.pop_data      (pop_data),
		.pop           (pop),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.verdict       (verdict_code)
	);

	assign verdict = verdict_code;

endmodule
